// ===== src/nvqp_pkg.sv =====
// shared types and constants for the nvme queue pair tracker
package nvqp_pkg;

    localparam int ID_W      = 6;
    localparam int DEPTH_W   = 7;
    localparam int COUNT_W   = 7;
    localparam int KIND_W    = 2;
    localparam int BELL_W    = 2;
    localparam int ENTRY_W   = 2;
    localparam int ID_SPACE  = 64;
    localparam int MAX_DEPTH = 64;
    localparam int APB_AW    = 3;
    localparam int APB_DW    = 32;

    // depth cap: never above the id space, never below two
    localparam int DEPTH_TOP = (MAX_DEPTH < ID_SPACE) ? MAX_DEPTH : ID_SPACE;
    localparam logic [DEPTH_W-1:0] DEPTH_MIN   = DEPTH_W'(2);
    localparam logic [DEPTH_W-1:0] DEPTH_MAX   = DEPTH_W'((DEPTH_TOP < 2) ? 2 : DEPTH_TOP);
    localparam logic [DEPTH_W-1:0] DEPTH_RESET = DEPTH_W'(64);
    localparam logic [COUNT_W-1:0] COUNT_MAX   = COUNT_W'(127);

    // request table entry bits
    localparam int ENT_DONE  = 0;
    localparam int ENT_WRITE = 1;

    localparam logic OP_WRITE = 1'b1;

    // register word index on the apb port
    localparam logic REG_QUEUE_DEPTH = 1'b0;

    typedef enum logic [KIND_W-1:0] {
        KIND_ALLOC  = 2'd0,
        KIND_SUBMIT = 2'd1,
        KIND_CMPL   = 2'd2,
        KIND_RING   = 2'd3
    } kind_t;

    typedef enum logic [BELL_W-1:0] {
        DB_NONE = 2'd0,
        DB_SQ   = 2'd1,
        DB_CQ   = 2'd2
    } bell_t;

endpackage

// ===== src/nvqp_if.sv =====
// event and result channel interfaces
interface nvqp_in_if import nvqp_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic              is_write;
    logic [ID_W-1:0]   cmd_tag;
    logic              entry_phase;

    modport source (output valid, kind, is_write, cmd_tag, entry_phase, input ready);
    modport sink   (input valid, kind, is_write, cmd_tag, entry_phase, output ready);
endinterface

interface nvqp_out_if import nvqp_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [ID_W-1:0]    allocated_id;
    logic [ID_W-1:0]    slot_index;
    logic               entry_accepted;
    logic [ID_W-1:0]    completed_id;
    logic [BELL_W-1:0]  doorbell;
    logic [ID_W-1:0]    doorbell_value;
    logic [COUNT_W-1:0] pending_writes;

    modport source (output valid, allocated_id, slot_index, entry_accepted, completed_id,
                    doorbell, doorbell_value, pending_writes, input ready);
    modport sink   (input valid, allocated_id, slot_index, entry_accepted, completed_id,
                    doorbell, doorbell_value, pending_writes, output ready);
endinterface

// ===== src/nvqp_ram.sv =====
// generic single write port ram with registered read
module nvqp_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/nvqp_regs.sv =====
// apb configuration register block and effective depth
module nvqp_regs import nvqp_pkg::*; (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [APB_AW-1:0]   paddr,
    input  logic [APB_DW-1:0]   pwdata,
    output logic [APB_DW-1:0]   prdata,
    output logic                pready,
    output logic [DEPTH_W-1:0]  eff_depth
);

    logic [DEPTH_W-1:0] queue_depth_reg;
    logic [DEPTH_W-1:0] queue_depth_next;
    logic               wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_comb
    begin
        queue_depth_next = queue_depth_reg;
        if (wr_en && paddr[APB_AW-1] == REG_QUEUE_DEPTH)
        begin
            queue_depth_next = pwdata[DEPTH_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            queue_depth_reg <= DEPTH_RESET;
        end
        else
        begin
            queue_depth_reg <= queue_depth_next;
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[APB_AW-1] == REG_QUEUE_DEPTH)
        begin
            prdata = {{(APB_DW-DEPTH_W){1'b0}}, queue_depth_reg};
        end
    end

    // clamp into the supported range
    always_comb
    begin
        if (queue_depth_reg < DEPTH_MIN)
        begin
            eff_depth = DEPTH_MIN;
        end
        else if (queue_depth_reg > DEPTH_MAX)
        begin
            eff_depth = DEPTH_MAX;
        end
        else
        begin
            eff_depth = queue_depth_reg;
        end
    end

endmodule

// ===== src/nvme_host_queue_pair_tracker.sv =====
// top level: nvme host queue pair tracker with request table in ram
// flow: an event waits in the compute stage, then moves into the result register
// throughput: one event per cycle unless results stall; the request table read at
//   transfer and write back at retire form a read-modify-write loop closed by a bypass
// reset: rst_n clears pointers, write count and id counter, sets the phase to one
//   and the depth to 64; per-entry valid flops make the table read as zero, no sweep
module nvme_host_queue_pair_tracker import nvqp_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [APB_AW-1:0]  paddr,
    input  logic [APB_DW-1:0]  pwdata,
    output logic [APB_DW-1:0]  prdata,
    output logic               pready,
    nvqp_in_if.sink            req,
    nvqp_out_if.source         rsp
);

    localparam int AW = $clog2(ID_SPACE);

    logic [DEPTH_W-1:0] eff_depth;

    // configuration port
    nvqp_regs u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .eff_depth (eff_depth)
    );

    // ------------------------------------------------------------------
    // queue state
    // ------------------------------------------------------------------
    logic [ID_W-1:0]    sub_tail_reg,  sub_tail_next;
    logic [ID_W-1:0]    comp_head_reg, comp_head_next;
    logic               phase_reg,     phase_next;
    logic [ID_W-1:0]    id_cnt_reg,    id_cnt_next;
    logic [COUNT_W-1:0] wcount_reg,    wcount_next;
    logic [ID_W-1:0]    rung_head_reg, rung_head_next;
    logic [ID_SPACE-1:0] ent_valid_reg;

    // compute stage: event waiting for its table read data
    logic               s1_valid_reg;
    kind_t              s1_kind_reg;
    logic               s1_wr_reg;
    logic [ID_W-1:0]    s1_cid_reg;
    logic               s1_phase_reg;
    logic               s1_byp_reg;
    logic [ENTRY_W-1:0] s1_byp_data_reg;

    // result register
    logic               out_valid_reg;
    logic [ID_W-1:0]    out_alloc_reg, out_alloc_next;
    logic [ID_W-1:0]    out_slot_reg,  out_slot_next;
    logic               out_acc_reg,   out_acc_next;
    logic [ID_W-1:0]    out_done_reg,  out_done_next;
    bell_t              out_bell_reg,  out_bell_next;
    logic [ID_W-1:0]    out_bval_reg,  out_bval_next;

    logic               s1_adv;
    logic               s1_fire;
    logic               in_fire;
    logic [ENTRY_W-1:0] ram_rdata;
    logic [ENTRY_W-1:0] old_entry;
    logic               tbl_we;
    logic [AW-1:0]      tbl_waddr;
    logic [ENTRY_W-1:0] tbl_wdata;
    logic               cmpl_acc;

    // the stage moves when the result register is free or being drained
    assign s1_adv  = !out_valid_reg || rsp.ready;
    assign s1_fire = s1_valid_reg && s1_adv;
    assign req.ready = !s1_valid_reg || s1_adv;
    assign in_fire = req.valid && req.ready;

    // request table: read at transfer, written back when the event retires
    nvqp_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (ID_SPACE)
    ) u_table (
        .clk   (clk),
        .we    (s1_fire && tbl_we),
        .waddr (tbl_waddr),
        .wdata (tbl_wdata),
        .re    (in_fire),
        .raddr (req.cmd_tag[AW-1:0]),
        .rdata (ram_rdata)
    );

    // bypass wins over the ram; an entry never written reads as zero
    always_comb
    begin
        if (s1_byp_reg)
        begin
            old_entry = s1_byp_data_reg;
        end
        else if (ent_valid_reg[s1_cid_reg[AW-1:0]])
        begin
            old_entry = ram_rdata;
        end
        else
        begin
            old_entry = '0;
        end
    end

    // ------------------------------------------------------------------
    // event processing
    // ------------------------------------------------------------------
    logic [ID_W-1:0]    cur;
    logic [DEPTH_W-1:0] nxt;

    always_comb
    begin
        sub_tail_next  = sub_tail_reg;
        comp_head_next = comp_head_reg;
        phase_next     = phase_reg;
        id_cnt_next    = id_cnt_reg;
        wcount_next    = wcount_reg;
        rung_head_next = rung_head_reg;
        out_alloc_next = '0;
        out_slot_next  = '0;
        out_acc_next   = 1'b0;
        out_done_next  = '0;
        out_bell_next  = DB_NONE;
        out_bval_next  = '0;
        tbl_we         = 1'b0;
        tbl_waddr      = s1_cid_reg[AW-1:0];
        tbl_wdata      = old_entry;
        cmpl_acc       = 1'b0;
        cur            = '0;
        nxt            = '0;

        unique case (s1_kind_reg)
            KIND_ALLOC:
            begin
                // a counter left beyond a lowered depth restarts at zero
                cur = ({1'b0, id_cnt_reg} >= eff_depth) ? '0 : id_cnt_reg;
                nxt = {1'b0, cur} + DEPTH_W'(1);
                id_cnt_next    = (nxt >= eff_depth) ? '0 : nxt[ID_W-1:0];
                out_alloc_next = cur;
                tbl_we    = 1'b1;
                tbl_waddr = cur[AW-1:0];
                tbl_wdata = '0;
            end
            KIND_SUBMIT:
            begin
                cur = ({1'b0, sub_tail_reg} >= eff_depth) ? '0 : sub_tail_reg;
                nxt = {1'b0, cur} + DEPTH_W'(1);
                sub_tail_next = (nxt >= eff_depth) ? '0 : nxt[ID_W-1:0];
                out_slot_next = cur;
                out_bell_next = DB_SQ;
                out_bval_next = sub_tail_next;
                tbl_we = 1'b1;
                tbl_wdata[ENT_WRITE] = (s1_wr_reg == OP_WRITE);
                if (s1_wr_reg == OP_WRITE && wcount_reg < COUNT_MAX)
                begin
                    wcount_next = wcount_reg + COUNT_W'(1);
                end
            end
            KIND_CMPL:
            begin
                if (s1_phase_reg == phase_reg)
                begin
                    cmpl_acc      = 1'b1;
                    out_acc_next  = 1'b1;
                    out_done_next = s1_cid_reg;
                    tbl_we = 1'b1;
                    tbl_wdata[ENT_DONE] = 1'b1;
                    // a repeated completion of a write retires again, floor at zero
                    if (old_entry[ENT_WRITE] && wcount_reg != '0)
                    begin
                        wcount_next = wcount_reg - COUNT_W'(1);
                    end
                    cur = ({1'b0, comp_head_reg} >= eff_depth) ? '0 : comp_head_reg;
                    nxt = {1'b0, cur} + DEPTH_W'(1);
                    if (nxt >= eff_depth)
                    begin
                        comp_head_next = '0;
                        phase_next     = !phase_reg;
                    end
                    else
                    begin
                        comp_head_next = nxt[ID_W-1:0];
                    end
                end
            end
            KIND_RING:
            begin
                // ring only when the head moved since the last ring
                if (comp_head_reg != rung_head_reg)
                begin
                    out_bell_next  = DB_CQ;
                    out_bval_next  = comp_head_reg;
                    rung_head_next = comp_head_reg;
                end
            end
        endcase
    end

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sub_tail_reg  <= '0;
            comp_head_reg <= '0;
            phase_reg     <= 1'b1;
            id_cnt_reg    <= '0;
            wcount_reg    <= '0;
            rung_head_reg <= '0;
            ent_valid_reg <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_fire)
            begin
                sub_tail_reg  <= sub_tail_next;
                comp_head_reg <= comp_head_next;
                phase_reg     <= phase_next;
                id_cnt_reg    <= id_cnt_next;
                wcount_reg    <= wcount_next;
                rung_head_reg <= rung_head_next;
                if (tbl_we)
                begin
                    ent_valid_reg[tbl_waddr] <= 1'b1;
                end
            end
            if (req.ready)
            begin
                s1_valid_reg <= req.valid;
            end
            if (s1_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_kind_reg  <= kind_t'(req.kind);
            s1_wr_reg    <= req.is_write;
            s1_cid_reg   <= req.cmd_tag;
            s1_phase_reg <= req.entry_phase;
            // write landing in the same cycle as this read: ram data is stale
            s1_byp_reg      <= s1_fire && tbl_we && (tbl_waddr == req.cmd_tag[AW-1:0]);
            s1_byp_data_reg <= tbl_wdata;
        end
        if (s1_fire)
        begin
            out_alloc_reg <= out_alloc_next;
            out_slot_reg  <= out_slot_next;
            out_acc_reg   <= out_acc_next;
            out_done_reg  <= out_done_next;
            out_bell_reg  <= out_bell_next;
            out_bval_reg  <= out_bval_next;
        end
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.allocated_id   = out_alloc_reg;
    assign rsp.slot_index     = out_slot_reg;
    assign rsp.entry_accepted = out_acc_reg;
    assign rsp.completed_id   = out_done_reg;
    assign rsp.doorbell       = out_bell_reg;
    assign rsp.doorbell_value = out_bval_reg;
    assign rsp.pending_writes = wcount_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_count_only_on_retire: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_fire |=> $stable(wcount_reg))
        else $error("write count changed without a retiring event");

    a_head_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire && cmpl_acc |=> {1'b0, comp_head_reg} < $past(eff_depth))
        else $error("completion head beyond depth");

    a_phase_on_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire && (phase_next != phase_reg) |=> comp_head_reg == '0)
        else $error("phase toggled without head wrap");

    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_adv |-> !req.ready)
        else $error("event taken while compute stage stalled");

    a_no_bell_on_cmpl: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.entry_accepted |-> rsp.doorbell == DB_NONE)
        else $error("doorbell raised by a completion entry");

endmodule

// ===== tb/nvqp_tb_pkg.sv =====
`timescale 1ns / 100ps
// shadow state of the queue pair tracker and the check of its results
package nvqp_tb_pkg;
    import nvqp_pkg::*;

    typedef struct packed {
        logic [ID_W-1:0]    allocated_id;
        logic [ID_W-1:0]    slot_index;
        logic               entry_accepted;
        logic [ID_W-1:0]    completed_id;
        logic [BELL_W-1:0]  doorbell;
        logic [ID_W-1:0]    doorbell_value;
        logic [COUNT_W-1:0] pending_writes;
    } qp_result_t;

    class queue_pair_shadow;
        logic [DEPTH_W-1:0] depth_reg;
        int unsigned        sq_tail;
        int unsigned        cq_head;
        int unsigned        id_next;
        int unsigned        rung_head;
        int unsigned        writes_out;
        int unsigned        last_alloc;
        bit                 want_phase;
        logic [ENTRY_W-1:0] req_state [ID_SPACE];
        qp_result_t         owed_results [$];

        int unsigned mismatches;
        int unsigned results_seen;
        int unsigned events_seen;
        int unsigned cmpl_taken;
        int unsigned cmpl_refused;
        int unsigned cq_bells;
        int unsigned ceiling_hits;
        int unsigned floor_hits;

        function new();
            depth_reg  = DEPTH_RESET;
            sq_tail    = 0;
            cq_head    = 0;
            id_next    = 0;
            rung_head  = 0;
            writes_out = 0;
            last_alloc = 0;
            want_phase = 1'b1;
            foreach (req_state[i])
                req_state[i] = '0;
        endfunction

        // a pointer left beyond a lowered depth counts as slot zero
        function int unsigned clip(int unsigned p, int unsigned d);
            return (p >= d) ? 0 : p;
        endfunction

        function int unsigned bump(int unsigned p, int unsigned d);
            return (p + 1 >= d) ? 0 : p + 1;
        endfunction

        function int unsigned pending();
            return owed_results.size();
        endfunction

        function void report_mismatch(string what);
            mismatches++;
            if (mismatches <= 50)
                $display("%0t mismatch %0d: %s", $time, mismatches, what);
        endfunction

        // one accepted event: update the shadow state and queue the result it owes
        function void note_event(kind_t k, bit wr, logic [ID_W-1:0] cid, bit ph);
            int unsigned d;
            int unsigned cur;
            qp_result_t  r;
            d = depth_reg;
            if (d < DEPTH_MIN)
                d = DEPTH_MIN;
            if (d > DEPTH_MAX)
                d = DEPTH_MAX;
            r = '0;
            events_seen++;
            case (k)
                KIND_ALLOC:
                begin
                    cur = clip(id_next, d);
                    r.allocated_id = ID_W'(cur);
                    req_state[cur] = '0;
                    id_next = bump(cur, d);
                    last_alloc = cur;
                end
                KIND_SUBMIT:
                begin
                    cur = clip(sq_tail, d);
                    r.slot_index = ID_W'(cur);
                    sq_tail = bump(cur, d);
                    r.doorbell = DB_SQ;
                    r.doorbell_value = ID_W'(sq_tail);
                    if (wr == OP_WRITE)
                    begin
                        req_state[cid][ENT_WRITE] = 1'b1;
                        if (writes_out < COUNT_MAX)
                            writes_out++;
                        else
                            ceiling_hits++;
                    end
                    else
                        req_state[cid][ENT_WRITE] = 1'b0;
                end
                KIND_CMPL:
                begin
                    if (ph == want_phase)
                    begin
                        cmpl_taken++;
                        r.entry_accepted = 1'b1;
                        r.completed_id = cid;
                        req_state[cid][ENT_DONE] = 1'b1;
                        if (req_state[cid][ENT_WRITE])
                        begin
                            if (writes_out > 0)
                                writes_out--;
                            else
                                floor_hits++;
                        end
                        cq_head = bump(clip(cq_head, d), d);
                        if (cq_head == 0)
                            want_phase = ~want_phase;
                    end
                    else
                        cmpl_refused++;
                end
                KIND_RING:
                begin
                    if (cq_head != rung_head)
                    begin
                        r.doorbell = DB_CQ;
                        r.doorbell_value = ID_W'(cq_head);
                        rung_head = cq_head;
                        cq_bells++;
                    end
                end
            endcase
            r.pending_writes = COUNT_W'(writes_out);
            owed_results.push_back(r);
        endfunction

        function void compare_field(string name, logic [7:0] got, logic [7:0] want);
            if (got !== want)
                report_mismatch($sformatf("result %0d %s: got %0h, want %0h",
                                          results_seen, name, got, want));
        endfunction

        function void check_result(qp_result_t got);
            qp_result_t want;
            results_seen++;
            if (owed_results.size() == 0)
                report_mismatch($sformatf("result %0d arrived with none owed: %h",
                                          results_seen, got));
            else
            begin
                want = owed_results.pop_front();
                compare_field("allocated_id", got.allocated_id, want.allocated_id);
                compare_field("slot_index", got.slot_index, want.slot_index);
                compare_field("entry_accepted", got.entry_accepted, want.entry_accepted);
                compare_field("completed_id", got.completed_id, want.completed_id);
                compare_field("doorbell", got.doorbell, want.doorbell);
                compare_field("doorbell_value", got.doorbell_value, want.doorbell_value);
                compare_field("pending_writes", got.pending_writes, want.pending_writes);
            end
        endfunction
    endclass

endpackage

// ===== tb/nvme_host_queue_pair_tracker_test.sv =====
`timescale 1ns / 100ps
// top-level testbench of the nvme queue pair tracker: stimulus, handshakes and run control
module nvme_host_queue_pair_tracker_test;
    import nvqp_pkg::*;
    import nvqp_tb_pkg::*;

    // no transfer on either channel for this many cycles means the block hung
    localparam int WATCHDOG_LIMIT = 4000;
    // idle wait after all owed results are back, before a register write and at the end of the run
    localparam int DRAIN_CYCLES = 4;
    localparam int PHASE_ITEMS = 85;
    localparam logic [APB_AW-1:0] DEPTH_ADDR = APB_AW'(4 * REG_QUEUE_DEPTH);

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    nvqp_in_if  req_ch ();
    nvqp_out_if rsp_ch ();

    nvme_host_queue_pair_tracker dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .req     (req_ch),
        .rsp     (rsp_ch)
    );

    queue_pair_shadow   shadow;
    bit                 src_quiet  = 1'b0;   // sender never idles while set
    bit                 sink_quiet = 1'b0;   // receiver starts no new stall while set
    int                 sink_stall = 0;
    int                 quiet_cycles = 0;
    int                 depth_settings = 0;
    logic [DEPTH_W-1:0] depth_plan [8];

    always #4 clk = ~clk;

    // mostly short gaps, now and then a long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 2);
        if (r < 95)
            return $urandom_range(3, 8);
        return $urandom_range(15, 40);
    endfunction

    // result side: random stalls of the receiver
    always @(posedge clk)
    begin
        if (!rst_n)
            rsp_ch.ready <= 1'b0;
        else if (sink_stall > 0)
        begin
            sink_stall--;
            rsp_ch.ready <= 1'b0;
        end
        else
        begin
            rsp_ch.ready <= 1'b1;
            if (!sink_quiet && $urandom_range(0, 99) < 20)
                sink_stall = gap_len();
        end
    end

    // result check on every transfer, plus the hang watchdog
    always @(posedge clk)
    begin : result_watch
        qp_result_t got;
        if (rst_n)
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                got = '{rsp_ch.allocated_id, rsp_ch.slot_index, rsp_ch.entry_accepted,
                        rsp_ch.completed_id, rsp_ch.doorbell, rsp_ch.doorbell_value,
                        rsp_ch.pending_writes};
                shadow.check_result(got);
            end
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
                $display("nvme_host_queue_pair_tracker_test NOT OK");
                $finish;
            end
        end
    end

    // one event transfer; valid stays high afterwards so back-to-back events need no re-raise
    task automatic send_event(kind_t k, bit wr, logic [ID_W-1:0] cid, bit ph);
        int gap;
        gap = 0;
        if (!src_quiet && $urandom_range(0, 99) < 40)
            gap = gap_len();
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.kind        <= k;
        req_ch.is_write    <= wr;
        req_ch.cmd_tag     <= cid;
        req_ch.entry_phase <= ph;
        do @(posedge clk); while (!req_ch.ready);
        shadow.note_event(k, wr, cid, ph);
    endtask

    // sender holds off until every owed result has come back
    task automatic settle();
        req_ch.valid <= 1'b0;
        do @(posedge clk); while (shadow.pending() != 0);
    endtask

    // register write on an idle block, then read it back
    task automatic set_depth(logic [DEPTH_W-1:0] value);
        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= DEPTH_ADDR;
        // upper data bits are junk the register must drop
        pwdata  <= ($urandom() & ~APB_DW'(7'h7F)) | APB_DW'(value);
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        shadow.depth_reg = value;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata[DEPTH_W-1:0] !== value)
            shadow.report_mismatch($sformatf("queue_depth read back %0h, wrote %0h",
                                             prdata[DEPTH_W-1:0], value));
        psel    <= 1'b0;
        penable <= 1'b0;
        depth_settings++;
    endtask

    // hand-picked events around reset depth and the smallest depth
    task automatic directed_items();
        // reset depth 64
        send_event(KIND_RING, 1'b1, 6'd63, 1'b1);     // ring with head unmoved
        send_event(KIND_ALLOC, 1'b0, 6'd0, 1'b0);
        send_event(KIND_ALLOC, 1'b1, 6'd63, 1'b1);
        send_event(KIND_SUBMIT, 1'b1, 6'd0, 1'b0);
        send_event(KIND_SUBMIT, 1'b0, 6'd63, 1'b0);
        send_event(KIND_SUBMIT, 1'b1, 6'd63, 1'b1);   // same id flips to a write
        send_event(KIND_CMPL, 1'b0, 6'd5, 1'b0);      // stale phase, refused
        send_event(KIND_CMPL, 1'b1, 6'd0, 1'b1);
        send_event(KIND_CMPL, 1'b0, 6'd0, 1'b1);      // repeat retires another write
        send_event(KIND_CMPL, 1'b0, 6'd0, 1'b1);      // count already at zero
        send_event(KIND_RING, 1'b0, 6'd0, 1'b0);
        send_event(KIND_RING, 1'b0, 6'd0, 1'b0);      // nothing moved since last ring
        send_event(KIND_CMPL, 1'b1, 6'd63, 1'b1);
        // smallest depth: every pointer is now past the end
        set_depth(DEPTH_MIN);
        send_event(KIND_ALLOC, 1'b0, 6'd0, 1'b0);
        send_event(KIND_ALLOC, 1'b0, 6'd0, 1'b0);
        send_event(KIND_ALLOC, 1'b0, 6'd0, 1'b0);     // id wraps
        send_event(KIND_SUBMIT, 1'b1, 6'd63, 1'b0);
        send_event(KIND_SUBMIT, 1'b1, 6'd1, 1'b0);    // tail wraps
        send_event(KIND_CMPL, 1'b0, 6'd63, 1'b1);
        send_event(KIND_CMPL, 1'b0, 6'd1, 1'b1);      // head wraps, phase flips
        send_event(KIND_CMPL, 1'b0, 6'd1, 1'b1);      // old phase now refused
        send_event(KIND_CMPL, 1'b0, 6'd1, 1'b0);
        send_event(KIND_RING, 1'b0, 6'd0, 1'b0);
        send_event(KIND_ALLOC, 1'b0, 6'd0, 1'b0);     // allocation clears the write flag
        send_event(KIND_CMPL, 1'b0, 6'd1, 1'b0);
    endtask

    // enough writes to pin the pending count at its ceiling, then drain some
    task automatic write_flood();
        logic [ID_W-1:0] ids [$];
        logic [ID_W-1:0] cid;
        for (int i = 0; i < 135; i++)
        begin
            cid = ID_W'($urandom_range(0, ID_SPACE - 1));
            ids.push_back(cid);
            send_event(KIND_SUBMIT, OP_WRITE, cid, 1'($urandom_range(0, 1)));
        end
        for (int i = 0; i < 20; i++)
            send_event(KIND_CMPL, 1'($urandom_range(0, 1)), ids.pop_front(),
                       shadow.want_phase);
        send_event(KIND_RING, 1'b0, 6'd0, 1'b0);
    endtask

    // random mix of allocate, submit, complete and ring, mostly on ids handed out earlier, with some noise mixed in
    task automatic random_phase(int n);
        logic [ID_W-1:0] handed [$];
        logic [ID_W-1:0] inflight [$];
        logic [ID_W-1:0] cid;
        int              r;
        int              pause_at;
        bit              wr;
        bit              ph;
        pause_at = ($urandom_range(0, 1) != 0) ? $urandom_range(n / 4, 3 * n / 4) : -1;
        for (int i = 0; i < n; i++)
        begin
            if (i == pause_at)
                settle();
            r   = $urandom_range(0, 99);
            wr  = 1'($urandom_range(0, 1));
            cid = ID_W'($urandom_range(0, ID_SPACE - 1));
            ph  = 1'($urandom_range(0, 1));
            if (r < 22)
            begin
                send_event(KIND_ALLOC, wr, cid, ph);
                handed.push_back(ID_W'(shadow.last_alloc));
            end
            else if (r < 50)
            begin
                if (handed.size() != 0 && $urandom_range(0, 9) < 7)
                    cid = handed.pop_front();
                inflight.push_back(cid);
                send_event(KIND_SUBMIT, wr, cid, ph);
            end
            else if (r < 85)
            begin
                if (inflight.size() != 0 && $urandom_range(0, 9) < 8)
                    cid = inflight.pop_front();
                // a stale phase now and then, as a not-yet-written entry would show
                ph = ($urandom_range(0, 99) < 85) ? shadow.want_phase : ~shadow.want_phase;
                send_event(KIND_CMPL, wr, cid, ph);
            end
            else
                send_event(KIND_RING, wr, cid, ph);
        end
    endtask

    initial
    begin
        clk                = 1'b0;
        rst_n              = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        req_ch.valid       = 1'b0;
        req_ch.kind        = KIND_ALLOC;
        req_ch.is_write    = 1'b0;
        req_ch.cmd_tag     = '0;
        req_ch.entry_phase = 1'b0;
        rsp_ch.ready       = 1'b0;
        shadow = new();
        // low and high clamps, odd sizes and a couple of random settings
        depth_plan = '{7'd3, 7'd127, 7'd0, 7'd1, DEPTH_MAX,
                       DEPTH_W'($urandom_range(2, 64)), 7'd65,
                       DEPTH_W'($urandom_range(0, 127))};

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_items();

        // full speed on both sides for the flood
        src_quiet  = 1'b1;
        sink_quiet = 1'b1;
        set_depth(DEPTH_MAX);
        write_flood();

        foreach (depth_plan[p])
        begin
            set_depth(depth_plan[p]);
            src_quiet  = (p % 3 == 2);
            sink_quiet = (p % 3 == 2);
            random_phase(PHASE_ITEMS);
        end

        src_quiet  = 1'b0;
        sink_quiet = 1'b0;
        settle();
        repeat (DRAIN_CYCLES * 4) @(posedge clk);

        $display("ran %0d events over %0d depth settings: %0d completions taken, %0d refused",
                 shadow.events_seen, depth_settings, shadow.cmpl_taken, shadow.cmpl_refused);
        $display("%0d cq doorbells, write count at ceiling %0d and at zero %0d times, %0d errors",
                 shadow.cq_bells, shadow.ceiling_hits, shadow.floor_hits, shadow.mismatches);
        if (shadow.mismatches == 0 && shadow.pending() == 0)
            $display("nvme_host_queue_pair_tracker_test OK");
        else
            $display("nvme_host_queue_pair_tracker_test NOT OK");
        $finish;
    end

endmodule
